>>> design/kmst_pkg.sv
// Shared types and constants for the key-matrix settle-time statistics unit.
// Used by every module of the block; depends on nothing.
package kmst_pkg;

    localparam int ROW_W     = 3;
    localparam int COLS_W    = 16;
    localparam int TICKS_W   = 16;
    localparam int CAPCOL_W  = 5;
    localparam int HELD_W    = 4;
    localparam int SAMPLE_W  = 16;
    localparam int TOUT_W    = 8;
    localparam int CLEAN_W   = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRIAL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_SCANS   = 4'd1;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [CLEAN_W-1:0] CLEAN_RESET   = 8'd16;

    localparam logic [CAPCOL_W-1:0] NO_COLUMN = 5'd16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;
    localparam logic [TOUT_W-1:0]   TOUT_MAX   = 8'hFF;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ROW_W-1:0]   row;
        logic [COLS_W-1:0]  column_states;
        logic               line_ready;
        logic               fall_seen;
        logic [TICKS_W-1:0] elapsed_ticks;
    } item_t;

    typedef struct packed {
        logic [CAPCOL_W-1:0] captured_column;
        logic [TICKS_W-1:0]  min_ticks;
        logic [TICKS_W-1:0]  max_ticks;
        logic [SAMPLE_W-1:0] sample_count;
        logic [TOUT_W-1:0]   timeout_count;
        logic                all_captured;
    } row_stats_t;

endpackage

>>> design/kmst_release_ctr.sv
// Clean-pass counter that decides when the matrix counts as released.
// Depends on kmst_pkg.
module kmst_release_ctr
    import kmst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  item_t              item,
    input  logic [CLEAN_W-1:0] clean_scans_needed,
    output logic               released
);

    logic [CLEAN_W-1:0] count_reg;
    logic [CLEAN_W-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        case (item.kind)
            KIND_RELEASE: begin
                if (item.column_states != '0) begin
                    count_next = '0;
                end else if (count_reg < clean_scans_needed) begin
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_CLEAR: count_next = '0;
            default:    count_next = count_reg;
        endcase
    end

    assign released = (count_next >= clean_scans_needed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (en) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> design/kmst_row_store.sv
// Per-row captured column and settle-time statistics, with their update logic.
// Depends on kmst_pkg.
module kmst_row_store
    import kmst_pkg::*;
#(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  item_t              item,
    input  logic [TICKS_W-1:0] timeout_ticks,
    output row_stats_t         stats
);

    localparam int IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam logic [COLS_W-1:0] COL_MASK = COLS_W'((33'd1 << COLUMN_COUNT) - 33'd1);

    logic [ROW_COUNT-1:0] held_reg;
    logic [HELD_W-1:0]    col_reg    [ROW_COUNT];
    logic [TICKS_W-1:0]   min_reg    [ROW_COUNT];
    logic [TICKS_W-1:0]   max_reg    [ROW_COUNT];
    logic [SAMPLE_W-1:0]  sample_reg [ROW_COUNT];
    logic [TOUT_W-1:0]    tout_reg   [ROW_COUNT];

    logic                 row_valid;
    logic [IDX_W-1:0]     idx;
    logic [COLS_W-1:0]    cols;
    logic [HELD_W-1:0]    lowest;
    logic                 any_pressed;
    logic                 do_capture;
    logic                 do_trial;
    logic                 timed_out;
    logic                 held_next;
    logic [HELD_W-1:0]    col_next;
    logic [TICKS_W-1:0]   min_next;
    logic [TICKS_W-1:0]   max_next;
    logic [SAMPLE_W-1:0]  sample_next;
    logic [TOUT_W-1:0]    tout_next;
    logic [ROW_COUNT-1:0] held_vec_next;

    assign row_valid = (32'(item.row) < ROW_COUNT);
    assign idx       = row_valid ? IDX_W'(item.row) : '0;
    assign cols      = item.column_states & COL_MASK;

    // Priority encoder: scanning down leaves the lowest set column.
    always_comb begin
        lowest = '0;
        for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
            if (cols[c]) begin
                lowest = HELD_W'(c);
            end
        end
    end

    assign any_pressed = (cols != '0);
    assign do_capture  = (item.kind == KIND_CAPTURE) && row_valid && !held_reg[idx]
                         && any_pressed;
    assign do_trial    = (item.kind == KIND_TRIAL) && row_valid && held_reg[idx];
    assign timed_out   = !item.line_ready || !item.fall_seen
                         || (item.elapsed_ticks >= timeout_ticks);

    always_comb begin
        held_next   = held_reg[idx];
        col_next    = col_reg[idx];
        min_next    = min_reg[idx];
        max_next    = max_reg[idx];
        sample_next = sample_reg[idx];
        tout_next   = tout_reg[idx];
        if (do_capture) begin
            held_next = 1'b1;
            col_next  = lowest;
        end
        if (do_trial) begin
            if (timed_out) begin
                if (tout_reg[idx] != TOUT_MAX) begin
                    tout_next = tout_reg[idx] + 1'b1;
                end
            end else begin
                if (sample_reg[idx] == '0) begin
                    min_next = item.elapsed_ticks;
                    max_next = item.elapsed_ticks;
                end else begin
                    if (item.elapsed_ticks < min_reg[idx]) begin
                        min_next = item.elapsed_ticks;
                    end
                    if (item.elapsed_ticks > max_reg[idx]) begin
                        max_next = item.elapsed_ticks;
                    end
                end
                if (sample_reg[idx] != SAMPLE_MAX) begin
                    sample_next = sample_reg[idx] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        held_vec_next = held_reg;
        if (item.kind == KIND_CLEAR) begin
            held_vec_next = '0;
        end else if (do_capture) begin
            held_vec_next[idx] = 1'b1;
        end
    end

    // A cleared table or an out-of-range row reports the reset values in the row fields.
    always_comb begin
        stats.all_captured = &held_vec_next;
        if (row_valid && (item.kind != KIND_CLEAR)) begin
            stats.captured_column = held_next ? {1'b0, col_next} : NO_COLUMN;
            stats.min_ticks       = min_next;
            stats.max_ticks       = max_next;
            stats.sample_count    = sample_next;
            stats.timeout_count   = tout_next;
        end else begin
            stats.captured_column = NO_COLUMN;
            stats.min_ticks       = '0;
            stats.max_ticks       = '0;
            stats.sample_count    = '0;
            stats.timeout_count   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                col_reg[r]    <= '0;
                min_reg[r]    <= '0;
                max_reg[r]    <= '0;
                sample_reg[r] <= '0;
                tout_reg[r]   <= '0;
            end
        end else if (en) begin
            held_reg <= held_vec_next;
            if (item.kind == KIND_CLEAR) begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                    col_reg[r]    <= '0;
                    min_reg[r]    <= '0;
                    max_reg[r]    <= '0;
                    sample_reg[r] <= '0;
                    tout_reg[r]   <= '0;
                end
            end else if (row_valid) begin
                col_reg[idx]    <= col_next;
                min_reg[idx]    <= min_next;
                max_reg[idx]    <= max_next;
                sample_reg[idx] <= sample_next;
                tout_reg[idx]   <= tout_next;
            end
        end
    end

endmodule

>>> design/key_matrix_settle_time_stats_unit.sv
// Top level of the key-matrix settle-time statistics unit: stream ports,
// input and result registers, configuration registers. Uses kmst_pkg,
// kmst_row_store and kmst_release_ctr.
//
//   Port group   Direction  Carries
//   s_*          in         one request: kind in tuser, scan/trial data in tdata
//   m_*          out        one result per request: row statistics and flags
//   cfg_*        in         register writes (index, data), always ready
//
// A request is registered on acceptance and its result is registered in the result
// register when it moves on, so one request can be accepted every cycle while
// results are taken. The whole update is one pass through the row store.
// When m_tready is low the result register holds, the input register still
// takes one more request, and then s_tready falls until the result is taken.
// Reset clears all statistics, sets timeout_ticks to 100 and
// clean_scans_needed to 16.
module key_matrix_settle_time_stats_unit
    import kmst_pkg::*;
#(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] row, [18:3] column_states, [19] line_ready, [20] fall_seen,
    // [36:21] elapsed_ticks, [39:37] zero
    input  logic [39:0]           s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] row_out, [7:3] captured_column, [23:8] min_ticks, [39:24] max_ticks,
    // [55:40] sample_count, [63:56] timeout_count, [64] released,
    // [65] all_captured, [71:66] zero
    output logic [71:0]           m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;
    logic [71:0]        out_data_next;
    logic [TICKS_W-1:0] timeout_ticks_reg;
    logic [CLEAN_W-1:0] clean_scans_reg;

    logic               advance;
    item_t              s_item;
    row_stats_t         stats;
    logic               released;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign s_item.kind          = s_tuser;
    assign s_item.row           = s_tdata[2:0];
    assign s_item.column_states = s_tdata[18:3];
    assign s_item.line_ready    = s_tdata[19];
    assign s_item.fall_seen     = s_tdata[20];
    assign s_item.elapsed_ticks = s_tdata[36:21];

    kmst_row_store #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_row_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .item          (in_item_reg),
        .timeout_ticks (timeout_ticks_reg),
        .stats         (stats)
    );

    kmst_release_ctr u_release (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (advance),
        .item               (in_item_reg),
        .clean_scans_needed (clean_scans_reg),
        .released           (released)
    );

    assign out_data_next = {6'b0, stats.all_captured, released, stats.timeout_count,
                            stats.sample_count, stats.max_ticks, stats.min_ticks,
                            stats.captured_column, in_item_reg.row};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RESET;
            clean_scans_reg   <= CLEAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                CFG_CLEAN_SCANS:   clean_scans_reg   <= cfg_data[CLEAN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> test/key_matrix_settle_time_stats_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_matrix_settle_time_stats_unit: drives scan and trial
// requests and register writes, and predicts every row report on its own.
// Depends on kmst_pkg and the unit's top level only.
module key_matrix_settle_time_stats_unit_tb
    import kmst_pkg::*;
();

    localparam int ROWS        = 8;
    localparam int STALL_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [CAPCOL_W-1:0] captured_column;
        logic [TICKS_W-1:0]  min_ticks;
        logic [TICKS_W-1:0]  max_ticks;
        logic [SAMPLE_W-1:0] sample_count;
        logic [TOUT_W-1:0]   timeout_count;
        logic                released;
        logic                all_captured;
    } row_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [71:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted copy of the unit's registers and per-row statistics.
    logic [TICKS_W-1:0]  cfg_timeout;
    logic [CLEAN_W-1:0]  cfg_clean_scans;
    logic [CAPCOL_W-1:0] held_col [ROWS];
    logic [TICKS_W-1:0]  row_min [ROWS];
    logic [TICKS_W-1:0]  row_max [ROWS];
    logic [SAMPLE_W-1:0] row_samples [ROWS];
    logic [TOUT_W-1:0]   row_timeouts [ROWS];
    logic [CLEAN_W-1:0]  clean_passes;

    row_report_t row_reports_due [$];
    row_report_t want_report;

    bit idle_enable = 1'b1;
    int error_count = 0;
    int result_count = 0;
    int cfg_write_count = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    key_matrix_settle_time_stats_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_row_stats();
        for (int r = 0; r < ROWS; r++) begin
            held_col[r]     = NO_COLUMN;
            row_min[r]      = '0;
            row_max[r]      = '0;
            row_samples[r]  = '0;
            row_timeouts[r] = '0;
        end
        clean_passes = '0;
    endfunction

    // Applies one request to the predicted state and returns the row report it causes.
    function automatic row_report_t apply_scan_event(item_t req);
        row_report_t rep;
        logic        all_held;
        int          r;
        r = int'(req.row);
        case (req.kind)
            KIND_RELEASE: begin
                if (req.column_states != '0)
                    clean_passes = '0;
                else if (clean_passes < cfg_clean_scans)
                    clean_passes = clean_passes + 1'b1;
            end
            KIND_CAPTURE: begin
                if (held_col[r] == NO_COLUMN) begin
                    for (int c = COLS_W - 1; c >= 0; c--)
                        if (req.column_states[c])
                            held_col[r] = CAPCOL_W'(c);
                end
            end
            KIND_TRIAL: begin
                if (held_col[r] != NO_COLUMN) begin
                    if (!req.line_ready || !req.fall_seen || req.elapsed_ticks >= cfg_timeout) begin
                        if (row_timeouts[r] != TOUT_MAX)
                            row_timeouts[r] = row_timeouts[r] + 1'b1;
                    end else begin
                        // The first sample of a row seeds both extremes.
                        if (row_samples[r] == '0) begin
                            row_min[r] = req.elapsed_ticks;
                            row_max[r] = req.elapsed_ticks;
                        end else begin
                            if (req.elapsed_ticks < row_min[r])
                                row_min[r] = req.elapsed_ticks;
                            if (req.elapsed_ticks > row_max[r])
                                row_max[r] = req.elapsed_ticks;
                        end
                        if (row_samples[r] != SAMPLE_MAX)
                            row_samples[r] = row_samples[r] + 1'b1;
                    end
                end
            end
            default: begin
                clear_row_stats();
            end
        endcase
        all_held = 1'b1;
        for (int i = 0; i < ROWS; i++)
            if (held_col[i] == NO_COLUMN)
                all_held = 1'b0;
        rep.row             = req.row;
        rep.captured_column = held_col[r];
        rep.min_ticks       = row_min[r];
        rep.max_ticks       = row_max[r];
        rep.sample_count    = row_samples[r];
        rep.timeout_count   = row_timeouts[r];
        rep.released        = (clean_passes >= cfg_clean_scans);
        rep.all_captured    = all_held;
        return rep;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: result %0d: %s", $realtime, result_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    // Sends one request, with an optional random gap first, and records its prediction.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                                input logic [COLS_W-1:0] cols, input logic ready,
                                input logic fall, input logic [TICKS_W-1:0] ticks);
        item_t req;
        int    gap;
        req.kind          = kind;
        req.row           = row;
        req.column_states = cols;
        req.line_ready    = ready;
        req.fall_seen     = fall;
        req.elapsed_ticks = ticks;
        if (idle_enable && $urandom_range(99) < 11) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {3'b000, req.elapsed_ticks, req.fall_seen, req.line_ready,
                     req.column_states, req.row};
        do @(posedge aclk); while (!s_tready);
        row_reports_due.push_back(apply_scan_event(req));
        kind_count[req.kind]++;
    endtask

    // Stops the request stream and waits until every report has come back.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (row_reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_TIMEOUT_TICKS)
            cfg_timeout = value;
        else if (index == CFG_CLEAN_SCANS)
            cfg_clean_scans = value[CLEAN_W-1:0];
        cfg_write_count++;
    endtask

    // Reset settings: capture rules, trial outcomes at the timeout edge, min/max update.
    task automatic test_reset_config();
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'd50);
        send_request(KIND_CAPTURE, 3'd2, 16'h0000, 1'b0, 1'b0, 16'd0);
        send_request(KIND_CAPTURE, 3'd2, 16'h8000, 1'b0, 1'b0, 16'd0);
        send_request(KIND_CAPTURE, 3'd2, 16'h0001, 1'b1, 1'b1, 16'hFFFF);
        send_request(KIND_TRIAL,   3'd2, 16'hFFFF, 1'b0, 1'b1, 16'd10);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b0, 16'd10);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'd100);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'd99);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'd0);
        send_request(KIND_RELEASE, 3'd5, 16'h0000, 1'b0, 1'b0, 16'd0);
    endtask

    // Zero and full-scale register values, and a write to an unused index.
    task automatic test_register_extremes();
        write_register(CFG_TIMEOUT_TICKS, 16'd0);
        write_register(CFG_CLEAN_SCANS, 16'd0);
        write_register(CFG_UNUSED, 16'hFFFF);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'd0);
        send_request(KIND_RELEASE, 3'd7, 16'hFFFF, 1'b1, 1'b1, 16'd0);
        write_register(CFG_TIMEOUT_TICKS, 16'hFFFF);
        // Only the low byte of the data reaches the clean-pass threshold.
        write_register(CFG_CLEAN_SCANS, 16'hFF02);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'hFFFE);
        send_request(KIND_TRIAL,   3'd2, 16'h0000, 1'b1, 1'b1, 16'hFFFF);
        repeat (3) send_request(KIND_RELEASE, 3'd0, 16'h0000, 1'b0, 1'b0, 16'd0);
        send_request(KIND_RELEASE, 3'd0, 16'h0400, 1'b0, 1'b0, 16'd0);
    endtask

    task automatic test_capture_all_rows();
        for (int r = 0; r < ROWS; r++)
            send_request(KIND_CAPTURE, ROW_W'(r), (r == ROWS - 1) ? 16'hFFFF : 16'h0100 << r[2:0],
                         1'b0, 1'b0, 16'd0);
        send_request(KIND_CLEAR, 3'd4, 16'h1234, 1'b1, 1'b1, 16'd77);
        send_request(KIND_TRIAL, 3'd0, 16'h0000, 1'b1, 1'b1, 16'd5);
    endtask

    // Runs one row into the saturating timeout counter at full speed.
    task automatic test_counter_saturation();
        int how;
        write_register(CFG_TIMEOUT_TICKS, 16'hFFFF);
        idle_enable = 1'b0;
        send_request(KIND_CLEAR, 3'd0, 16'h0000, 1'b0, 1'b0, 16'd0);
        send_request(KIND_CAPTURE, 3'd1, 16'h0002, 1'b0, 1'b0, 16'd0);
        repeat (20)
            send_request(KIND_TRIAL, 3'd1, COLS_W'($urandom), 1'b1, 1'b1,
                         TICKS_W'($urandom_range(65534)));
        repeat (260) begin
            how = $urandom_range(2);
            send_request(KIND_TRIAL, 3'd1, COLS_W'($urandom), how == 1, how == 0,
                         TICKS_W'($urandom));
        end
        idle_enable = 1'b1;
    endtask

    // Mostly well-formed traffic: clean-pass runs, captures and trials on random rows.
    task automatic test_random_traffic(input logic [TICKS_W-1:0] timeout,
                                       input logic [CLEAN_W-1:0] clean,
                                       input int count, input bit idling);
        int               sent;
        int               pick;
        int               run_len;
        logic [7:0]       junk;
        logic [COLS_W-1:0] cols;
        logic [TICKS_W-1:0] ticks;
        logic             rdy;
        logic             fall;
        junk = 8'($urandom);
        write_register(CFG_TIMEOUT_TICKS, timeout);
        write_register(CFG_CLEAN_SCANS, {junk, clean});
        idle_enable = idling;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_request(KIND_CLEAR, ROW_W'($urandom), COLS_W'($urandom), 1'($urandom),
                             1'($urandom), TICKS_W'($urandom));
                sent++;
            end else if (pick < 25) begin
                run_len = $urandom_range(12, 1);
                repeat (run_len)
                    send_request(KIND_RELEASE, ROW_W'($urandom), 16'h0000, 1'($urandom),
                                 1'($urandom), TICKS_W'($urandom));
                sent += run_len;
                if ($urandom_range(3) == 0) begin
                    cols = (16'h1 << $urandom_range(15)) | 16'($urandom);
                    send_request(KIND_RELEASE, ROW_W'($urandom), cols, 1'($urandom),
                                 1'($urandom), TICKS_W'($urandom));
                    sent++;
                end
            end else if (pick < 45) begin
                pick = $urandom_range(99);
                if (pick < 15)
                    cols = '0;
                else if (pick < 60)
                    cols = 16'h1 << $urandom_range(15);
                else
                    cols = COLS_W'($urandom);
                send_request(KIND_CAPTURE, ROW_W'($urandom), cols, 1'($urandom),
                             1'($urandom), TICKS_W'($urandom));
                sent++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 60)
                    ticks = TICKS_W'($urandom_range(cfg_timeout));
                else if (pick < 80)
                    ticks = TICKS_W'($urandom);
                else
                    ticks = ($urandom_range(1) == 0) ? cfg_timeout : cfg_timeout - 1'b1;
                if ($urandom_range(99) < 80) begin
                    rdy  = 1'b1;
                    fall = 1'b1;
                end else begin
                    rdy  = 1'($urandom);
                    fall = 1'($urandom);
                end
                send_request(KIND_TRIAL, ROW_W'($urandom), COLS_W'($urandom), rdy, fall, ticks);
                sent++;
            end
        end
        idle_enable = 1'b1;
    endtask

    always @(posedge aclk) begin
        m_tready <= !(idle_enable && $urandom_range(99) < 22);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (row_reports_due.size() == 0) begin
                report_error($sformatf("report %0h arrived with none outstanding", m_tdata));
            end else begin
                want_report = row_reports_due.pop_front();
                check_field("row_out", 16'(m_tdata[2:0]), 16'(want_report.row));
                check_field("captured_column", 16'(m_tdata[7:3]),
                            16'(want_report.captured_column));
                check_field("min_ticks", m_tdata[23:8], want_report.min_ticks);
                check_field("max_ticks", m_tdata[39:24], want_report.max_ticks);
                check_field("sample_count", m_tdata[55:40], want_report.sample_count);
                check_field("timeout_count", 16'(m_tdata[63:56]),
                            16'(want_report.timeout_count));
                check_field("released", 16'(m_tdata[64]), 16'(want_report.released));
                check_field("all_captured", 16'(m_tdata[65]), 16'(want_report.all_captured));
                check_field("padding", 16'(m_tdata[71:66]), 16'd0);
            end
        end
    end

    // Ends the run if no channel has moved anything for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        cfg_timeout     = TIMEOUT_RESET;
        cfg_clean_scans = CLEAN_RESET;
        clear_row_stats();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_register_extremes();
        test_capture_all_rows();
        test_counter_saturation();
        test_random_traffic(TICKS_W'($urandom_range(65535, 1)),
                            CLEAN_W'($urandom_range(8, 1)), 60, 1'b1);
        test_random_traffic(16'hFFFF, 8'd255, 60, 1'b1);
        test_random_traffic(16'd1, 8'd1, 60, 1'b0);
        test_random_traffic(TICKS_W'($urandom_range(400, 1)),
                            CLEAN_W'($urandom_range(20, 1)), 60, 1'b1);

        drain_requests();
        repeat (6) @(posedge aclk);
        $display("Sent %0d release, %0d capture, %0d trial and %0d clear requests;",
                 kind_count[KIND_RELEASE], kind_count[KIND_CAPTURE],
                 kind_count[KIND_TRIAL], kind_count[KIND_CLEAR]);
        $display("checked %0d row reports across %0d register writes, %0d mismatches.",
                 result_count, cfg_write_count, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
